[hdl/ptp_pkg.sv]
// Shared widths, stage positions and types of the point-to-triangle projection pipeline.
`timescale 1ns / 1ps

package ptp_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int HALF_W     = DOT_W / 2;
  localparam int WIDE_W     = 2 * DOT_W;
  localparam int QTR_W      = WIDE_W / 4;
  localparam int NUM_W      = WIDE_W + DIFF_W + 2;
  localparam int QUO_W      = DIFF_W + 1;

  localparam int ST_DIFF = 1;
  localparam int ST_PROD = 2;
  localparam int ST_DOT  = 3;
  localparam int ST_MULA = 4;
  localparam int ST_DST  = 6;
  localparam int ST_MULB = 7;
  localparam int ST_M    = 9;
  localparam int ST_DVD  = 10;
  localparam int ST_DIV  = 11;
  localparam int ST_OUT  = ST_DIV + QUO_W;
  localparam int DEPTH   = ST_OUT + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;
  typedef logic signed [NUM_W-1:0]      num_t;
  typedef logic [NUM_W-1:0]             udiv_t;
  typedef logic [WIDE_W-1:0]            den_t;
  typedef logic [QUO_W-1:0]             quo_t;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] base;
    logic [2:0][DIFF_W-1:0]     u;
    logic [2:0][DIFF_W-1:0]     v;
    logic [WIDE_W-1:0]          d;
    logic                       hit;
    logic                       degen;
    logic [2:0]                 neg;
  } side_t;

endpackage

[hdl/point_triangle_projection.sv]
// Top level of the barycentric point-in-triangle test and projection pipeline.
`timescale 1ns / 1ps
//
// Each input item carries a query point P and triangle vertices A, B and C in
// signed Q11.12. Each item gives one result item: inside_res, degenerate and
// the projected point qx, qy, qz, which is zero unless the point is inside.
// A triangle with zero area is flagged as degenerate and reported outside.
// Both channels use valid and stall; an item moves at a clock edge at which
// valid is high and stall is low.
// The pipeline has 38 register stages. One item can be accepted in every
// cycle in which in_stall is low; the depth is set by the wide cofactor
// multipliers and by the 26-stage divider, which produces one quotient bit
// per stage.
// When the receiver stalls, the output holds and the stages behind it keep
// filling any empty slots, so items are still accepted until every stage is
// occupied. Reset empties the pipeline; no item is lost or repeated by stalls.
//

module point_triangle_projection import ptp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  coord_t px,
  input  coord_t py,
  input  coord_t pz,
  input  coord_t ax,
  input  coord_t ay,
  input  coord_t az,
  input  coord_t bx,
  input  coord_t by_,
  input  coord_t bz,
  input  coord_t cx,
  input  coord_t cy,
  input  coord_t cz,
  output logic   out_valid,
  input  logic   out_stall,
  output logic   inside_res,
  output logic   degenerate,
  output coord_t qx,
  output coord_t qy,
  output coord_t qz
);

  logic [DEPTH-1:0] valid;
  logic [DEPTH:0]   go;

  side_t side [ST_OUT];
  side_t sn   [ST_OUT];

  coord_t pr [3], ar [3], br [3], cr [3];
  diff_t  u [3], v [3], w [3];
  prod_t  puu [3], puv [3], pvv [3], pwu [3], pwv [3];
  dot_t   uu, uv, vv, wu, wv;
  wide_t  m_uuvv, m_uvuv, m_vvwu, m_uvwv, m_uuwv, m_uvwu;
  wide_t  dd, ss, tt, ds, dst;
  diff_t  ub [3], vb [3];
  num_t   su [3], tv [3], mm [3];
  udiv_t  dvd [3];
  quo_t   quo [3];
  coord_t res [3];
  logic   ok;

  assign go[DEPTH] = !out_stall;
  for (genvar i = 0; i < DEPTH; i++) begin : g_go
    assign go[i] = !valid[i] || go[i+1];
  end

  assign in_stall  = !go[0];
  assign out_valid = valid[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (go[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (go[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  always_comb begin
    ds  = dd - ss;
    dst = ds - tt;
    sn[0] = '0;
    for (int i = 1; i < ST_OUT; i++) begin
      sn[i] = side[i-1];
    end
    sn[0].base = {az, ay, ax};
    for (int k = 0; k < 3; k++) begin
      sn[ST_PROD].u[k]  = u[k];
      sn[ST_PROD].v[k]  = v[k];
      sn[ST_DVD].neg[k] = mm[k][NUM_W-1];
    end
    sn[ST_MULB].d     = dd;
    sn[ST_MULB].degen = (dd == '0);
    sn[ST_MULB].hit   = !ss[WIDE_W-1] && !ds[WIDE_W-1] && !tt[WIDE_W-1] && !dst[WIDE_W-1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ST_OUT; i++) begin
      if (go[i]) begin
        side[i] <= sn[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      pr[0] <= px;
      pr[1] <= py;
      pr[2] <= pz;
      ar[0] <= ax;
      ar[1] <= ay;
      ar[2] <= az;
      br[0] <= bx;
      br[1] <= by_;
      br[2] <= bz;
      cr[0] <= cx;
      cr[1] <= cy;
      cr[2] <= cz;
    end
    for (int k = 0; k < 3; k++) begin
      if (go[ST_DIFF]) begin
        u[k] <= DIFF_W'(br[k]) - DIFF_W'(ar[k]);
        v[k] <= DIFF_W'(cr[k]) - DIFF_W'(ar[k]);
        w[k] <= DIFF_W'(pr[k]) - DIFF_W'(ar[k]);
      end
      if (go[ST_PROD]) begin
        puu[k] <= PROD_W'(u[k]) * PROD_W'(u[k]);
        puv[k] <= PROD_W'(u[k]) * PROD_W'(v[k]);
        pvv[k] <= PROD_W'(v[k]) * PROD_W'(v[k]);
        pwu[k] <= PROD_W'(w[k]) * PROD_W'(u[k]);
        pwv[k] <= PROD_W'(w[k]) * PROD_W'(v[k]);
      end
    end
    if (go[ST_DOT]) begin
      uu <= DOT_W'(puu[0]) + DOT_W'(puu[1]) + DOT_W'(puu[2]);
      uv <= DOT_W'(puv[0]) + DOT_W'(puv[1]) + DOT_W'(puv[2]);
      vv <= DOT_W'(pvv[0]) + DOT_W'(pvv[1]) + DOT_W'(pvv[2]);
      wu <= DOT_W'(pwu[0]) + DOT_W'(pwu[1]) + DOT_W'(pwu[2]);
      wv <= DOT_W'(pwv[0]) + DOT_W'(pwv[1]) + DOT_W'(pwv[2]);
    end
    if (go[ST_DST]) begin
      dd <= m_uuvv - m_uvuv;
      ss <= m_vvwu - m_uvwv;
      tt <= m_uuwv - m_uvwu;
    end
    for (int k = 0; k < 3; k++) begin
      if (go[ST_M]) begin
        mm[k] <= ((su[k] + tv[k]) <<< 1) + $signed(NUM_W'(side[ST_M-1].d));
      end
      if (go[ST_DVD]) begin
        if (mm[k][NUM_W-1]) begin
          dvd[k] <= (NUM_W'(side[ST_DVD-1].d) << 1) - NUM_W'(1) - udiv_t'(mm[k]);
        end else begin
          dvd[k] <= udiv_t'(mm[k]);
        end
      end
    end
  end

  ptp_mul52 u_mul_uuvv (.clk(clk), .en(go[ST_MULA +: 2]), .a(uu), .b(vv), .p(m_uuvv));
  ptp_mul52 u_mul_uvuv (.clk(clk), .en(go[ST_MULA +: 2]), .a(uv), .b(uv), .p(m_uvuv));
  ptp_mul52 u_mul_vvwu (.clk(clk), .en(go[ST_MULA +: 2]), .a(vv), .b(wu), .p(m_vvwu));
  ptp_mul52 u_mul_uvwv (.clk(clk), .en(go[ST_MULA +: 2]), .a(uv), .b(wv), .p(m_uvwv));
  ptp_mul52 u_mul_uuwv (.clk(clk), .en(go[ST_MULA +: 2]), .a(uu), .b(wv), .p(m_uuwv));
  ptp_mul52 u_mul_uvwu (.clk(clk), .en(go[ST_MULA +: 2]), .a(uv), .b(wu), .p(m_uvwu));

  for (genvar k = 0; k < 3; k++) begin : g_coord
    assign ub[k] = side[ST_DST].u[k];
    assign vb[k] = side[ST_DST].v[k];

    ptp_mul104 u_mul_su (.clk(clk), .en(go[ST_MULB +: 2]), .a(ss), .b(ub[k]), .p(su[k]));
    ptp_mul104 u_mul_tv (.clk(clk), .en(go[ST_MULB +: 2]), .a(tt), .b(vb[k]), .p(tv[k]));

    ptp_div u_div (
      .clk(clk),
      .en (go[ST_DIV +: QUO_W]),
      .num(dvd[k]),
      .den({side[ST_DVD].d[WIDE_W-2:0], 1'b0}),
      .quo(quo[k])
    );

    assign res[k] = side[ST_OUT-1].neg[k]
                  ? coord_t'(side[ST_OUT-1].base[k]) - coord_t'(quo[k][COORD_BITS-1:0])
                  : coord_t'(side[ST_OUT-1].base[k]) + coord_t'(quo[k][COORD_BITS-1:0]);
  end

  assign ok = side[ST_OUT-1].hit && !side[ST_OUT-1].degen;

  always_ff @(posedge clk) begin
    if (go[ST_OUT]) begin
      inside_res <= ok;
      degenerate <= side[ST_OUT-1].degen;
      qx <= ok ? res[0] : '0;
      qy <= ok ? res[1] : '0;
      qz <= ok ? res[2] : '0;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> valid == '0)
    else $error("Pipeline not empty after reset.");

  a_degen_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(inside_res && degenerate))
    else $error("Degenerate triangle reported inside.");

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> qx == '0 && qy == '0 && qz == '0)
    else $error("Projected point not zero for an outside item.");

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    valid[ST_OUT-1] && ok |-> !quo[0][QUO_W-1] && !quo[1][QUO_W-1] && !quo[2][QUO_W-1])
    else $error("Quotient out of range for an inside item.");

endmodule

[hdl/ptp_mul52.sv]
// Two-stage signed multiplier for dot products, built from four narrow partial products.
`timescale 1ns / 1ps

module ptp_mul52 import ptp_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  dot_t       a,
  input  dot_t       b,
  output wide_t      p
);

  logic signed [HALF_W-1:0] ah, bh;
  logic signed [HALF_W:0]   al, bl;
  logic signed [DOT_W+1:0]  hh, hl, lh, ll;

  assign ah = a[DOT_W-1:HALF_W];
  assign bh = b[DOT_W-1:HALF_W];
  assign al = {1'b0, a[HALF_W-1:0]};
  assign bl = {1'b0, b[HALF_W-1:0]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hh <= (DOT_W+2)'(ah) * (DOT_W+2)'(bh);
      hl <= (DOT_W+2)'(ah) * (DOT_W+2)'(bl);
      lh <= (DOT_W+2)'(al) * (DOT_W+2)'(bh);
      ll <= (DOT_W+2)'(al) * (DOT_W+2)'(bl);
    end
    if (en[1]) begin
      p <= (WIDE_W'(hh) <<< (2 * HALF_W)) + ((WIDE_W'(hl) + WIDE_W'(lh)) <<< HALF_W)
           + WIDE_W'(ll);
    end
  end

endmodule

[hdl/ptp_mul104.sv]
// Two-stage signed multiplier of a wide cofactor by an edge component, in four slices.
`timescale 1ns / 1ps

module ptp_mul104 import ptp_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  wide_t      a,
  input  diff_t      b,
  output num_t       p
);

  logic signed [QTR_W:0]        ch [4];
  logic signed [QTR_W+DIFF_W:0] pp [4];
  num_t                         acc;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ch[k] = {1'b0, a[k*QTR_W +: QTR_W]};
    end
    ch[3] = {a[WIDE_W-1], a[WIDE_W-1 -: QTR_W]};
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      acc = acc + (NUM_W'(pp[k]) <<< (k * QTR_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 4; k++) begin
        pp[k] <= (QTR_W+DIFF_W+1)'(ch[k]) * (QTR_W+DIFF_W+1)'(b);
      end
    end
    if (en[1]) begin
      p <= acc;
    end
  end

endmodule

[hdl/ptp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module ptp_div import ptp_pkg::*; (
  input  logic             clk,
  input  logic [QUO_W-1:0] en,
  input  udiv_t            num,
  input  den_t             den,
  output quo_t             quo
);

  udiv_t rem [QUO_W];
  den_t  dv  [QUO_W];
  quo_t  qb  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    udiv_t          rin;
    den_t           din;
    quo_t           qin;
    logic [NUM_W:0] trial;

    if (j == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem[j-1];
      assign din = dv[j-1];
      assign qin = qb[j-1];
    end

    assign trial = {1'b0, rin} - ((NUM_W + 1)'(din) << (QUO_W - 1 - j));

    always_ff @(posedge clk) begin
      if (en[j]) begin
        dv[j] <= din;
        if (!trial[NUM_W]) begin
          rem[j] <= trial[NUM_W-1:0];
          qb[j]  <= {qin[QUO_W-2:0], 1'b1};
        end else begin
          rem[j] <= rin;
          qb[j]  <= {qin[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = qb[QUO_W-1];

endmodule
